// ----- sv/arfm_pkg.sv -----
// Shared types, constants and helpers for the auto-ranging frequency meter.
// No dependencies; every other file refers to it by scoped names.
package arfm_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int HZ_WIDTH    = 27;
    localparam int GAIN_WIDTH  = 16;
    localparam int FREQ_WIDTH  = 40;
    localparam int GAIN_SHIFT  = 24;
    localparam int NUM_WIDTH   = COUNT_WIDTH + HZ_WIDTH;
    localparam int DVD_WIDTH   = NUM_WIDTH + FRAC_BITS;
    localparam int DCNT_WIDTH  = $clog2(DVD_WIDTH);
    localparam int CFG_IDX_WIDTH = 3;

    localparam logic [HZ_WIDTH-1:0]    RST_REF_HZ  = HZ_WIDTH'(4000000);
    localparam logic [31:0]            RST_GATE    = 32'd4000000;
    localparam logic [HZ_WIDTH-1:0]    RST_THR     = HZ_WIDTH'(10001);
    localparam logic [GAIN_WIDTH-1:0]  RST_SIG_GAIN = GAIN_WIDTH'(1117);
    localparam logic [GAIN_WIDTH-1:0]  RST_CLK_GAIN = GAIN_WIDTH'(864);
    localparam logic                   RST_MODE    = 1'b1;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_REF_HZ   = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_GATE     = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_THR      = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SIG_GAIN = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CLK_GAIN = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_INIT_MODE = 3'd5;

    localparam logic MODE_SYNC   = 1'b0;
    localparam logic MODE_PERIOD = 1'b1;

    typedef struct packed {
        logic accept;     // any item taken (edge tracker follows)
        logic tick;       // item belongs to a measurement
        logic begin_meas; // start tick: gate count restarts at one
        logic gate_clr;
        logic sig_clr;
        logic sig_inc;
        logic ref_clr;
        logic ref_inc;
        logic cal_s;
        logic cal_c;
        logic mul;
        logic div_load;
        logic div_step;
        logic fin_zero;   // timeout result
        logic fin_calc;   // computed result
    } arfm_cmd_t;

    typedef struct packed {
        logic rising;
        logic expired;
        logic zero;
        logic div_last;
        logic mode;
        logic out_full;
    } arfm_status_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

endpackage

// ----- sv/arfm_ctrl.sv -----
// Measurement sequencer for the frequency meter: phase FSM issuing datapath commands.
// Depends on arfm_pkg.
module arfm_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_start_req,
    input  arfm_pkg::arfm_status_t  status,
    output arfm_pkg::arfm_cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SYNC_OPEN, ST_SYNC_RUN, ST_SYNC_CLOSE, ST_PER_FIRST, ST_PER_RUN,
        ST_CAL_S, ST_CAL_C, ST_MUL, ST_DIV_LOAD, ST_DIV_RUN, ST_FIN
    } state_t;

    state_t state_reg, state_next, eff;
    logic   counting, acc;

    assign counting = (state_reg == ST_IDLE) || (state_reg == ST_SYNC_OPEN) ||
                      (state_reg == ST_SYNC_RUN) || (state_reg == ST_SYNC_CLOSE) ||
                      (state_reg == ST_PER_FIRST) || (state_reg == ST_PER_RUN);
    assign s_ready  = counting && !status.out_full;
    assign acc      = s_valid && s_ready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        eff        = state_reg;
        cmd.accept = acc;
        if (state_reg == ST_IDLE && s_start_req) begin
            eff = (status.mode == arfm_pkg::MODE_PERIOD) ? ST_PER_FIRST : ST_SYNC_OPEN;
        end
        if (acc && eff != ST_IDLE) begin
            cmd.tick = 1'b1;
            if (state_reg == ST_IDLE) begin
                cmd.begin_meas = 1'b1;
                cmd.sig_clr    = 1'b1;
                cmd.ref_clr    = 1'b1;
                state_next     = eff;
            end
        end
        unique case (state_reg)
            ST_CAL_S:    state_next = ST_CAL_C;
            ST_CAL_C:    state_next = ST_MUL;
            ST_MUL:      state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: begin
                if (status.zero) begin
                    cmd.fin_calc = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV_RUN;
                end
            end
            ST_DIV_RUN: begin
                cmd.div_step = 1'b1;
                if (status.div_last) state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.fin_calc = 1'b1;
                state_next   = ST_IDLE;
            end
            default: ;
        endcase
        if (state_reg == ST_CAL_S) cmd.cal_s = 1'b1;
        if (state_reg == ST_CAL_C) cmd.cal_c = 1'b1;
        if (state_reg == ST_MUL)   cmd.mul   = 1'b1;
        if (cmd.tick) begin
            unique case (eff)
                ST_SYNC_OPEN: begin
                    if (status.rising) begin
                        cmd.sig_clr = 1'b1;
                        cmd.ref_clr = 1'b1;
                        state_next  = ST_SYNC_RUN;
                    end else if (status.expired) begin
                        cmd.fin_zero = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                ST_SYNC_RUN: begin
                    cmd.ref_inc = 1'b1;
                    cmd.sig_inc = status.rising;
                    if (status.expired) begin
                        cmd.gate_clr = 1'b1;
                        state_next   = ST_SYNC_CLOSE;
                    end
                end
                ST_SYNC_CLOSE: begin
                    cmd.ref_inc = 1'b1;
                    if (status.rising) begin
                        cmd.sig_inc = 1'b1;
                        state_next  = ST_CAL_S;
                    end else if (status.expired) begin
                        cmd.fin_zero = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                ST_PER_FIRST: begin
                    if (status.rising) begin
                        cmd.ref_clr = 1'b1;
                        state_next  = ST_PER_RUN;
                    end else if (status.expired) begin
                        cmd.fin_zero = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                ST_PER_RUN: begin
                    cmd.ref_inc = 1'b1;
                    if (status.rising) begin
                        state_next = ST_CAL_S;
                    end else if (status.expired) begin
                        cmd.fin_zero = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && status.out_full)) else $error("input taken while result slot full");
    a_div_only_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_load |-> !status.zero) else $error("division started on zero count");
    a_single_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.fin_zero && cmd.fin_calc)) else $error("two results in one cycle");
`endif

endmodule

// ----- sv/arfm_dp.sv -----
// Datapath of the frequency meter: config registers, counters, calibration,
// multiplier, radix-2 restoring divider and result register. Depends on arfm_pkg.
module arfm_dp (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  arfm_pkg::arfm_cmd_t                       cmd,
    output arfm_pkg::arfm_status_t                    status,
    input  logic                                      s_sig_level,
    input  logic                                      cfg_valid,
    input  logic [arfm_pkg::CFG_IDX_WIDTH-1:0]        cfg_index,
    input  logic [31:0]                               cfg_data,
    input  logic                                      m_ready,
    output logic                                      m_valid,
    output logic [arfm_pkg::FREQ_WIDTH-1:0]           m_freq_q16,
    output logic [31:0]                               m_sig_total,
    output logic [31:0]                               m_ref_total,
    output logic                                      m_mode_used,
    output logic                                      m_no_signal
);

    localparam int CW = arfm_pkg::COUNT_WIDTH;
    localparam int PW = CW + arfm_pkg::GAIN_WIDTH;

    logic [arfm_pkg::HZ_WIDTH-1:0]   ref_hz_reg, thr_reg;
    logic [31:0]                     gate_ticks_reg;
    logic [arfm_pkg::GAIN_WIDTH-1:0] sg_reg, cg_reg;
    logic                            mode_reg, last_level_reg;
    logic [31:0]                     gate_reg, gate_next;
    logic [CW-1:0]                   sig_reg, ref_reg, s_reg, c_reg;
    logic [PW-1:0]                   prod_reg;
    logic [arfm_pkg::NUM_WIDTH-1:0]  num_reg;
    logic [arfm_pkg::DVD_WIDTH-1:0]  dvd_reg;
    logic [CW-1:0]                   rem_reg;
    logic [arfm_pkg::FREQ_WIDTH-1:0] q_reg, freq_next;
    logic                            sat_reg;
    logic [arfm_pkg::DCNT_WIDTH-1:0] dcnt_reg;
    logic [CW:0]                     cal_sum, r2;
    logic [CW-1:0]                   cal_val;
    logic                            ge, zero;

    assign gate_next = cmd.begin_meas ? 32'd1 : arfm_pkg::sat_inc32(gate_reg);
    assign zero      = (s_reg == '0) || (c_reg == '0);

    // calibrated value = count + count*gain/2^24, saturating
    assign cal_sum = {1'b0, (cmd.cal_c ? sig_reg : ref_reg)} +
                     (CW+1)'(prod_reg[PW-1:arfm_pkg::GAIN_SHIFT]);
    assign cal_val = cal_sum[CW] ? '1 : cal_sum[CW-1:0];

    assign r2 = {rem_reg, dvd_reg[arfm_pkg::DVD_WIDTH-1]};
    assign ge = r2 >= {1'b0, c_reg};

    assign freq_next = zero ? '0 : (sat_reg ? '1 : q_reg);

    always_comb begin
        status          = '0;
        status.rising   = s_sig_level && !last_level_reg;
        status.expired  = gate_next >= gate_ticks_reg;
        status.zero     = zero;
        status.div_last = (dcnt_reg == '0);
        status.mode     = mode_reg;
        status.out_full = m_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_hz_reg     <= arfm_pkg::RST_REF_HZ;
            gate_ticks_reg <= arfm_pkg::RST_GATE;
            thr_reg        <= arfm_pkg::RST_THR;
            sg_reg         <= arfm_pkg::RST_SIG_GAIN;
            cg_reg         <= arfm_pkg::RST_CLK_GAIN;
            mode_reg       <= arfm_pkg::RST_MODE;
            last_level_reg <= 1'b0;
            gate_reg       <= '0;
            sig_reg        <= '0;
            ref_reg        <= '0;
            m_valid        <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    arfm_pkg::REG_REF_HZ:   ref_hz_reg     <= cfg_data[arfm_pkg::HZ_WIDTH-1:0];
                    arfm_pkg::REG_GATE:     gate_ticks_reg <= cfg_data;
                    arfm_pkg::REG_THR:      thr_reg        <= cfg_data[arfm_pkg::HZ_WIDTH-1:0];
                    arfm_pkg::REG_SIG_GAIN: sg_reg <= cfg_data[arfm_pkg::GAIN_WIDTH-1:0];
                    arfm_pkg::REG_CLK_GAIN: cg_reg <= cfg_data[arfm_pkg::GAIN_WIDTH-1:0];
                    arfm_pkg::REG_INIT_MODE: begin
                        mode_reg      <= cfg_data[0];
                    end
                    default: ;
                endcase
            end
            if (cmd.accept) last_level_reg <= s_sig_level;
            if (cmd.tick) begin
                gate_reg <= cmd.gate_clr ? '0 : gate_next;
                if (cmd.sig_clr)      sig_reg <= '0;
                else if (cmd.sig_inc) sig_reg <= (sig_reg == '1) ? sig_reg : sig_reg + 1'b1;
                if (cmd.ref_clr)      ref_reg <= '0;
                else if (cmd.ref_inc) ref_reg <= (ref_reg == '1) ? ref_reg : ref_reg + 1'b1;
            end
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (cmd.fin_zero || cmd.fin_calc) begin
                m_valid  <= 1'b1;
                // results below the threshold go to period mode next time
                mode_reg <= ({3'b000, (cmd.fin_zero ? {arfm_pkg::FREQ_WIDTH{1'b0}}
                                                    : freq_next)} <
                             {thr_reg, {arfm_pkg::FRAC_BITS{1'b0}}}) ? arfm_pkg::MODE_PERIOD
                                                                      : arfm_pkg::MODE_SYNC;
            end
        end
    end

    // arithmetic and result payload
    always_ff @(posedge aclk) begin
        if (cmd.cal_s) prod_reg <= sig_reg * sg_reg;
        if (cmd.cal_c) begin
            s_reg    <= (mode_reg == arfm_pkg::MODE_PERIOD) ? CW'(1) : cal_val;
            prod_reg <= ref_reg * cg_reg;
        end
        if (cmd.mul) begin
            c_reg   <= (mode_reg == arfm_pkg::MODE_PERIOD) ? ref_reg : cal_val;
            num_reg <= s_reg * ref_hz_reg;
        end
        if (cmd.div_load) begin
            dvd_reg  <= {num_reg, {arfm_pkg::FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            q_reg    <= '0;
            sat_reg  <= 1'b0;
            dcnt_reg <= arfm_pkg::DCNT_WIDTH'(arfm_pkg::DVD_WIDTH - 1);
        end else if (cmd.div_step) begin
            dvd_reg  <= dvd_reg << 1;
            rem_reg  <= ge ? CW'(r2 - {1'b0, c_reg}) : r2[CW-1:0];
            q_reg    <= {q_reg[arfm_pkg::FREQ_WIDTH-2:0], ge};
            if (ge && dcnt_reg >= arfm_pkg::DCNT_WIDTH'(arfm_pkg::FREQ_WIDTH)) sat_reg <= 1'b1;
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.fin_zero) begin
            m_freq_q16  <= '0;
            m_sig_total <= '0;
            m_ref_total <= '0;
            m_mode_used <= mode_reg;
            m_no_signal <= 1'b1;
        end else if (cmd.fin_calc) begin
            m_freq_q16  <= freq_next;
            m_sig_total <= (mode_reg == arfm_pkg::MODE_PERIOD) ? '0 : s_reg;
            m_ref_total <= c_reg;
            m_mode_used <= mode_reg;
            m_no_signal <= zero;
        end
    end

`ifndef SYNTHESIS
    a_fin_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fin_zero || cmd.fin_calc) |-> !m_valid) else $error("result overwritten");
    a_nosig_zero_freq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_no_signal) |-> (m_freq_q16 == '0)) else $error("no-signal with freq");
    a_period_sig_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_mode_used) |-> (m_sig_total == '0)) else $error("period sig_total");
`endif

endmodule

// ----- sv/auto_ranging_frequency_meter.sv -----
// Auto-ranging reciprocal frequency meter, top level: sequencer plus datapath.
// One input item per reference tick; counting phases take an item every cycle.
// A timeout result appears in the cycle after the tick that ends the measurement;
// a computed result passes through calibrate, multiply, divider load, divider steps
// and finish states, during which no item is taken. Input stalls while a result waits.
// Synchronous active-low reset restores register defaults and idles; mode = period.
module auto_ranging_frequency_meter (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_start_req,
    input  logic                                  s_sig_level,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [arfm_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [31:0]                           cfg_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [arfm_pkg::FREQ_WIDTH-1:0]       m_freq_q16,
    output logic [31:0]                           m_sig_total,
    output logic [31:0]                           m_ref_total,
    output logic                                  m_mode_used,
    output logic                                  m_no_signal
);

    arfm_pkg::arfm_cmd_t    cmd;
    arfm_pkg::arfm_status_t status;

    assign cfg_ready = 1'b1;

    arfm_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_start_req (s_start_req),
        .status      (status),
        .cmd         (cmd)
    );

    arfm_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_sig_level (s_sig_level),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_freq_q16  (m_freq_q16),
        .m_sig_total (m_sig_total),
        .m_ref_total (m_ref_total),
        .m_mode_used (m_mode_used),
        .m_no_signal (m_no_signal)
    );

endmodule

// ----- test/testbench.sv -----
// Self-checking bench for auto_ranging_frequency_meter: directed and random tick streams.
// Expected results come from an in-bench model of the meter; depends on arfm_pkg and the top.
`timescale 1ns / 100ps

module testbench;

    localparam logic [39:0] F_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] C_MAX = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SYNC_OPEN, ST_SYNC_RUN, ST_SYNC_CLOSE, ST_PER_FIRST, ST_PER_RUN
    } meas_state_t;

    typedef struct {
        logic [39:0] freq;
        logic [31:0] sig_total;
        logic [31:0] ref_total;
        logic        mode_used;
        logic        no_signal;
    } reading_t;

    logic aclk, aresetn;
    logic s_valid, s_ready, s_start_req, s_sig_level;
    logic cfg_valid, cfg_ready;
    logic [arfm_pkg::CFG_IDX_WIDTH-1:0] cfg_index;
    logic [31:0] cfg_data;
    logic m_valid, m_ready;
    logic [39:0] m_freq_q16;
    logic [31:0] m_sig_total, m_ref_total;
    logic m_mode_used, m_no_signal;

    auto_ranging_frequency_meter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_req(s_start_req), .s_sig_level(s_sig_level),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_freq_q16(m_freq_q16), .m_sig_total(m_sig_total), .m_ref_total(m_ref_total),
        .m_mode_used(m_mode_used), .m_no_signal(m_no_signal)
    );

    // meter model: registers and state
    logic [26:0] mdl_ref_hz, mdl_thr;
    logic [31:0] mdl_gate;
    logic [15:0] mdl_sig_gain, mdl_clk_gain;
    logic        mdl_init_mode, mdl_mode, mdl_last;
    meas_state_t mdl_state;
    logic [31:0] mdl_gcnt, mdl_scnt, mdl_rcnt;

    reading_t pending_readings[$];
    int unsigned mismatches = 0;
    int unsigned burst_left = 0;

    // signal generator
    logic w_level = 1'b0;
    int unsigned w_half = 3, w_cnt = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [31:0] cnt_inc(input logic [31:0] c);
        return (c == C_MAX) ? c : c + 32'd1;
    endfunction

    function automatic logic [31:0] calibrate(input logic [31:0] c, input logic [15:0] g);
        logic [63:0] r;
        r = {32'd0, c} + (({32'd0, c} * {48'd0, g}) >> 24);
        return (r > {32'd0, C_MAX}) ? C_MAX : r[31:0];
    endfunction

    function automatic logic [39:0] freq_ratio(input logic [31:0] a, input logic [26:0] hz,
                                               input logic [31:0] den);
        logic [127:0] num, q;
        if (den == 0) return 40'd0;
        num = ({96'd0, a} * {101'd0, hz}) << arfm_pkg::FRAC_BITS;
        q = num / {96'd0, den};
        return (q > {88'd0, F_MAX}) ? F_MAX : q[39:0];
    endfunction

    function automatic void close_meas(input logic [39:0] f, input logic [31:0] st,
                                       input logic [31:0] rt, input logic used,
                                       input logic nosig);
        reading_t r;
        r.freq = f; r.sig_total = st; r.ref_total = rt;
        r.mode_used = used; r.no_signal = nosig;
        pending_readings.push_back(r);
        mdl_mode = ({3'd0, f} < {mdl_thr, 16'd0}) ? arfm_pkg::MODE_PERIOD
                                                   : arfm_pkg::MODE_SYNC;
        mdl_state = ST_IDLE;
    endfunction

    function automatic void meter_tick(input logic start, input logic lvl);
        logic rising, expired;
        logic [31:0] s, c;
        rising = lvl && !mdl_last;
        mdl_last = lvl;
        if (mdl_state == ST_IDLE) begin
            if (!start) return;
            mdl_state = (mdl_mode != arfm_pkg::MODE_SYNC) ? ST_PER_FIRST : ST_SYNC_OPEN;
            mdl_gcnt = 0; mdl_scnt = 0; mdl_rcnt = 0;
        end
        mdl_gcnt = cnt_inc(mdl_gcnt);
        expired = mdl_gcnt >= mdl_gate;
        case (mdl_state)
            ST_SYNC_OPEN: begin
                if (rising) begin
                    mdl_scnt = 0; mdl_rcnt = 0;
                    mdl_state = ST_SYNC_RUN;
                end else if (expired) close_meas(0, 0, 0, arfm_pkg::MODE_SYNC, 1'b1);
            end
            ST_SYNC_RUN: begin
                mdl_rcnt = cnt_inc(mdl_rcnt);
                if (rising) mdl_scnt = cnt_inc(mdl_scnt);
                if (expired) begin
                    mdl_state = ST_SYNC_CLOSE;
                    mdl_gcnt = 0;
                end
            end
            ST_SYNC_CLOSE: begin
                mdl_rcnt = cnt_inc(mdl_rcnt);
                if (rising) begin
                    mdl_scnt = cnt_inc(mdl_scnt);
                    s = calibrate(mdl_scnt, mdl_sig_gain);
                    c = calibrate(mdl_rcnt, mdl_clk_gain);
                    if (s == 0 || c == 0) close_meas(0, s, c, arfm_pkg::MODE_SYNC, 1'b1);
                    else close_meas(freq_ratio(s, mdl_ref_hz, c), s, c,
                                    arfm_pkg::MODE_SYNC, 1'b0);
                end else if (expired) close_meas(0, 0, 0, arfm_pkg::MODE_SYNC, 1'b1);
            end
            ST_PER_FIRST: begin
                if (rising) begin
                    mdl_rcnt = 0;
                    mdl_state = ST_PER_RUN;
                end else if (expired) close_meas(0, 0, 0, arfm_pkg::MODE_PERIOD, 1'b1);
            end
            ST_PER_RUN: begin
                mdl_rcnt = cnt_inc(mdl_rcnt);
                if (rising) begin
                    if (mdl_rcnt == 0) close_meas(0, 0, 0, arfm_pkg::MODE_PERIOD, 1'b1);
                    else close_meas(freq_ratio(32'd1, mdl_ref_hz, mdl_rcnt), 0, mdl_rcnt,
                                    arfm_pkg::MODE_PERIOD, 1'b0);
                end else if (expired) close_meas(0, 0, 0, arfm_pkg::MODE_PERIOD, 1'b1);
            end
            default: mdl_state = ST_IDLE;
        endcase
    endfunction

    function automatic logic wave_next();
        if (w_cnt >= w_half) begin
            w_cnt = 0;
            w_level = ~w_level;
        end
        w_cnt++;
        // occasional glitch
        if ($urandom_range(0, 19) == 0) return ~w_level;
        return w_level;
    endfunction

    task automatic send_item(input logic st, input logic lv);
        s_valid <= 1'b1;
        s_start_req <= st;
        s_sig_level <= lv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        meter_tick(st, lv);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 25);
        end else begin
            burst_left--;
        end
    endtask

    task automatic reg_write(input logic [arfm_pkg::CFG_IDX_WIDTH-1:0] idx,
                             input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            arfm_pkg::REG_REF_HZ:    mdl_ref_hz = val[26:0];
            arfm_pkg::REG_GATE:      mdl_gate = val;
            arfm_pkg::REG_THR:       mdl_thr = val[26:0];
            arfm_pkg::REG_SIG_GAIN:  mdl_sig_gain = val[15:0];
            arfm_pkg::REG_CLK_GAIN:  mdl_clk_gain = val[15:0];
            arfm_pkg::REG_INIT_MODE: begin
                mdl_init_mode = val[0];
                mdl_mode = val[0];
            end
            default: ;
        endcase
    endtask

    // finish any open measurement, then hold off until every reading is in
    task automatic settle();
        while (mdl_state != ST_IDLE) send_item(1'b0, wave_next());
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_all(input logic [26:0] hz, input logic [31:0] gate,
                           input logic [26:0] thr, input logic [15:0] sg,
                           input logic [15:0] cg, input logic im);
        reg_write(arfm_pkg::REG_REF_HZ, {5'd0, hz});
        reg_write(arfm_pkg::REG_GATE, gate);
        reg_write(arfm_pkg::REG_THR, {5'd0, thr});
        reg_write(arfm_pkg::REG_SIG_GAIN, {16'd0, sg});
        reg_write(arfm_pkg::REG_CLK_GAIN, {16'd0, cg});
        reg_write(arfm_pkg::REG_INIT_MODE, {31'd0, im});
    endtask

    task automatic test_period_defaults();
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        settle();
    endtask

    task automatic test_sync_extremes();
        set_all(27'd100000000, 32'd1, 27'd0, 16'hFFFF, 16'hFFFF, arfm_pkg::MODE_SYNC);
        send_item(1'b1, 1'b0);
        for (int i = 0; i < 8; i++) send_item(1'b0, i[0]);
        settle();
        reg_write(arfm_pkg::REG_GATE, 32'd4);
        send_item(1'b1, 1'b1);
        for (int i = 0; i < 8; i++) send_item(1'b1, ~i[0]);
        settle();
    endtask

    task automatic test_timeouts();
        set_all(27'd4000000, 32'd3, 27'd100000000, 16'd0, 16'd0, arfm_pkg::MODE_PERIOD);
        for (int i = 0; i < 4; i++) send_item(1'b1, 1'b0);
        settle();
        set_all(27'd4000000, 32'd3, 27'd0, 16'd0, 16'd0, arfm_pkg::MODE_SYNC);
        for (int i = 0; i < 4; i++) send_item(1'b1, 1'b0);
        settle();
    endtask

    task automatic test_ref_clock_ends();
        set_all(27'd0, 32'd20, 27'd50, 16'd1117, 16'd864, arfm_pkg::MODE_SYNC);
        send_item(1'b1, 1'b1);
        settle();
        set_all(27'd1, 32'd20, 27'd50, 16'd0, 16'hFFFF, arfm_pkg::MODE_PERIOD);
        send_item(1'b1, 1'b1);
        settle();
    endtask

    task automatic test_max_gate();
        set_all(27'd1, C_MAX, 27'd100000000, 16'd7, 16'd9, arfm_pkg::MODE_PERIOD);
        send_item(1'b1, 1'b0);
        settle();
    endtask

    task automatic test_random();
        logic [26:0] hz, thr;
        logic [31:0] gate;
        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 3))
                0: hz = 27'd1;
                1: hz = 27'd100000000;
                default: hz = $urandom_range(1, 100000000);
            endcase
            case ($urandom_range(0, 3))
                0: thr = 27'd0;
                1: thr = 27'd100000000;
                default: thr = $urandom_range(0, 2000000);
            endcase
            gate = ($urandom_range(0, 5) == 0) ? 32'd1 : $urandom_range(2, 40);
            set_all(hz, gate, thr,
                    ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom),
                    ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom),
                    1'($urandom));
            w_half = $urandom_range(1, 10);
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(0, 15) == 0) w_half = $urandom_range(1, 10);
                if (mdl_state == ST_IDLE)
                    send_item($urandom_range(0, 9) < 7, wave_next());
                else
                    send_item($urandom_range(0, 9) < 3, wave_next());
            end
            settle();
        end
    endtask

    // receiver stall pattern
    int unsigned rcv_cyc = 0;
    int unsigned rcv_mode = 0;
    always @(posedge aclk) begin
        rcv_cyc <= rcv_cyc + 1;
        if (rcv_cyc % 300 == 0) rcv_mode <= $urandom_range(0, 2);
        case (rcv_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom);
            default: m_ready <= (rcv_cyc % 5 == 0);
        endcase
    end

    always @(posedge aclk) begin
        reading_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected reading freq=%h", m_freq_q16);
            end else begin
                exp_r = pending_readings.pop_front();
                if (m_freq_q16 !== exp_r.freq || m_sig_total !== exp_r.sig_total ||
                    m_ref_total !== exp_r.ref_total || m_mode_used !== exp_r.mode_used ||
                    m_no_signal !== exp_r.no_signal) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp f=%h s=%h r=%h m=%b n=%b ",
                                  "got f=%h s=%h r=%h m=%b n=%b"},
                                 exp_r.freq, exp_r.sig_total, exp_r.ref_total,
                                 exp_r.mode_used, exp_r.no_signal, m_freq_q16,
                                 m_sig_total, m_ref_total, m_mode_used, m_no_signal);
                end
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0; s_start_req <= 1'b0; s_sig_level <= 1'b0;
        cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
        m_ready <= 1'b0;
        mdl_ref_hz = arfm_pkg::RST_REF_HZ; mdl_gate = arfm_pkg::RST_GATE;
        mdl_thr = arfm_pkg::RST_THR;
        mdl_sig_gain = arfm_pkg::RST_SIG_GAIN; mdl_clk_gain = arfm_pkg::RST_CLK_GAIN;
        mdl_init_mode = arfm_pkg::RST_MODE; mdl_mode = arfm_pkg::RST_MODE;
        mdl_state = ST_IDLE; mdl_gcnt = 0; mdl_scnt = 0; mdl_rcnt = 0; mdl_last = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_period_defaults();
        test_sync_extremes();
        test_timeouts();
        test_ref_clock_ends();
        test_max_gate();
        test_random();
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
